// File: rtl/pst_pkg.sv
`default_nettype none

package pst_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FOUND_W     = 5;

  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_REGISTER = 1'b1;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] period_ticks;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        fired;
    logic [3:0]  slot;
    logic        status;
    logic [63:0] tick_count;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic tick_start;
    logic reg_start;
    logic scan_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic used_zero;
    logic scan_last;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/pst_ctrl.sv
`default_nettype none

module pst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_cmd,
  input  wire pst_pkg::stat_t stat,
  output logic               busy,
  output pst_pkg::ctrl_t     ctrl
);

  pst_pkg::state_t state_r;
  pst_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    busy      = 1'b1;
    unique case (state_r)
      pst_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_cmd == pst_pkg::CMD_REGISTER) begin
            ctrl.reg_start = 1'b1;
          end else begin
            ctrl.tick_start = 1'b1;
            state_nxt = stat.used_zero ? pst_pkg::ST_DONE : pst_pkg::ST_SCAN;
          end
        end
      end
      pst_pkg::ST_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = pst_pkg::ST_DONE;
        end
      end
      pst_pkg::ST_DONE: begin
        ctrl.finish = 1'b1;
        state_nxt   = pst_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pst_datapath.sv
`default_nettype none

module pst_datapath #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pst_pkg::in_item_t in_item,
  input  wire pst_pkg::ctrl_t    ctrl,
  output pst_pkg::stat_t         stat,
  output logic                   out_valid,
  output pst_pkg::out_item_t     out_item
);

  localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned USED_W = $clog2(SLOT_COUNT + 1);

  logic [31:0] rem_mem [SLOT_COUNT];
  logic [31:0] rel_mem [SLOT_COUNT];

  logic [63:0]             tick_counter_r, tick_counter_nxt;
  logic [USED_W-1:0]       slots_used_r, slots_used_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    pending_v_r, pending_v_nxt;
  logic [3:0]              pending_slot_r, pending_slot_nxt;
  logic [pst_pkg::FOUND_W-1:0] found_r, found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pst_pkg::out_item_t      out_item_r, out_item_nxt;
  logic [31:0]             rd_rem_r, rd_rel_r;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             rem_we, rel_we;
  logic [31:0]      rem_wdata;
  logic             fire;

  assign fire = (rd_rem_r == 32'd0);

  assign stat.used_zero = (slots_used_r == '0);
  assign stat.scan_last = (USED_W'(USED_W'(idx_r) + USED_W'(1)) == slots_used_r);

  always_comb begin
    if (ctrl.tick_start || idx_r == IDX_W'(SLOT_COUNT - 1)) begin
      rd_addr = '0;
    end else begin
      rd_addr = IDX_W'(idx_r + IDX_W'(1));
    end
  end

  always_comb begin
    tick_counter_nxt = tick_counter_r;
    slots_used_nxt   = slots_used_r;
    idx_nxt          = idx_r;
    pending_v_nxt    = pending_v_r;
    pending_slot_nxt = pending_slot_r;
    found_nxt        = found_r;
    out_valid_nxt    = 1'b0;
    out_item_nxt     = out_item_r;
    rem_we           = 1'b0;
    rel_we           = 1'b0;
    rem_wdata        = in_item.period_ticks;
    wr_addr          = slots_used_r[IDX_W-1:0];

    if (ctrl.reg_start) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.kind       = pst_pkg::KIND_ACK;
      out_item_nxt.fired      = 1'b0;
      out_item_nxt.tick_count = tick_counter_r;
      out_item_nxt.last       = 1'b1;
      if (slots_used_r != USED_W'(SLOT_COUNT)) begin
        out_item_nxt.slot   = 4'(slots_used_r);
        out_item_nxt.status = pst_pkg::STATUS_OK;
        rem_we              = 1'b1;
        rel_we              = 1'b1;
        slots_used_nxt      = USED_W'(slots_used_r + USED_W'(1));
      end else begin
        out_item_nxt.slot   = 4'd0;
        out_item_nxt.status = pst_pkg::STATUS_FULL;
      end
    end

    if (ctrl.tick_start) begin
      tick_counter_nxt = tick_counter_r + 64'd1;
      idx_nxt          = '0;
      pending_v_nxt    = 1'b0;
      found_nxt        = '0;
    end

    if (ctrl.scan_step) begin
      rem_we    = 1'b1;
      wr_addr   = idx_r;
      rem_wdata = fire ? rd_rel_r : rd_rem_r - 32'd1;
      idx_nxt   = IDX_W'(idx_r + IDX_W'(1));
      if (fire && found_r < pst_pkg::FOUND_W'(pst_pkg::MAX_RESULTS)) begin
        found_nxt        = pst_pkg::FOUND_W'(found_r + pst_pkg::FOUND_W'(1));
        pending_v_nxt    = 1'b1;
        pending_slot_nxt = 4'(idx_r);
        if (pending_v_r) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.kind       = pst_pkg::KIND_TICK;
          out_item_nxt.fired      = 1'b1;
          out_item_nxt.slot       = pending_slot_r;
          out_item_nxt.status     = pst_pkg::STATUS_OK;
          out_item_nxt.tick_count = tick_counter_r;
          out_item_nxt.last       = 1'b0;
        end
      end
    end

    if (ctrl.finish) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.kind       = pst_pkg::KIND_TICK;
      out_item_nxt.fired      = pending_v_r;
      out_item_nxt.slot       = pending_v_r ? pending_slot_r : 4'd0;
      out_item_nxt.status     = pst_pkg::STATUS_OK;
      out_item_nxt.tick_count = tick_counter_r;
      out_item_nxt.last       = 1'b1;
      pending_v_nxt           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_counter_r <= '0;
      slots_used_r   <= '0;
      idx_r          <= '0;
      pending_v_r    <= 1'b0;
      found_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      tick_counter_r <= tick_counter_nxt;
      slots_used_r   <= slots_used_nxt;
      idx_r          <= idx_nxt;
      pending_v_r    <= pending_v_nxt;
      found_r        <= found_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pending_slot_r <= pending_slot_nxt;
    out_item_r     <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
    if (rel_we) begin
      rel_mem[wr_addr] <= in_item.period_ticks;
    end
    rd_rem_r <= rem_mem[rd_addr];
    rd_rel_r <= rel_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: rtl/periodic_slot_timer.sv
`default_nettype none

// Periodic slot timer with a 64-bit tick counter that each tick item advances.
// An item is transferred when start is high and busy is low. A registration
// item claims the next free slot with its reload period and produces one
// acknowledge result on the cycle after the transfer; a full table gives a
// refusal instead. Registration stays in the idle state, so busy stays low.
// A tick item advances the counter and visits each used slot in turn, one
// slot per cycle through the slot memory's single read port; busy stays high
// until its final report is issued.
// Each firing slot (at most MAX_RESULTS) produces one result; the last result
// of a tick carries last, and a tick with no firing slot gives one plain report.
// Results appear on out_item for exactly one cycle while out_valid is high;
// the receiver cannot stall them. Reset clears the counter and the table
// fill count; slot contents are not cleared and need no clearing pass.

module periodic_slot_timer #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pst_pkg::in_item_t in_item,
  output logic                   out_valid,
  output pst_pkg::out_item_t     out_item
);

  pst_pkg::ctrl_t ctrl;
  pst_pkg::stat_t stat;

  pst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.cmd),
    .stat   (stat),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  pst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
